/* sv/uft_pkg.sv */
// shared types, constants and tables for the fat timestamp encoder
package uft_pkg;

  localparam int NUM_STAGES = 10;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

  // saturation thresholds in unix seconds
  localparam logic [32:0] LO_SEC = 33'd315532800;
  localparam logic [32:0] HI_SEC = 33'd4354819200;

  // reciprocals for exact division by constants: q = (x * RECIP) >> shift
  localparam logic [26:0] DAY_RECIP  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam logic [20:0] ERA_RECIP  = 21'(((64'd1 << 38) + 64'd146096) / 64'd146097);
  localparam logic [18:0] RECIP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RECIP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] MP_RECIP   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [17:0] MIN_RECIP  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
  localparam logic [11:0] HOUR_RECIP = 12'(((64'd1 << 17) + 64'd59) / 64'd60);

  localparam logic [19:0] EPOCH_SHIFT   = 20'd719468;
  localparam logic [19:0] ERA_DAYS      = 20'd146097;
  localparam logic [11:0] FAT_YEAR_BASE = 12'd1980;

  localparam logic [15:0] FAT_DATE_MIN = 16'h0021;
  localparam logic [15:0] FAT_TIME_MIN = 16'h0000;
  localparam logic [15:0] FAT_DATE_MAX = 16'hFF9F;
  localparam logic [15:0] FAT_TIME_MAX = 16'hBF7D;

  // first day-of-year of each month, counted from march
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/uft_split.sv */
// split unix seconds into day count and second of day, plus range flags
module uft_split (
  input  logic              clk,
  input  uft_pkg::pipe_ctl_t ctl,
  input  logic [32:0]       seconds,
  output logic [16:0]       days,
  output logic [16:0]       sod,
  output logic              below,
  output logic              above
);
  import uft_pkg::*;

  // 86400 = 128 * 675: shift off the low seven bits, then divide by 675
  logic [25:0] hi_part_nxt;
  logic [52:0] prod_nxt;
  logic [25:0] hi_part_r;
  logic [52:0] prod_r;
  logic [6:0]  low_r;
  logic        below0_r, above0_r;

  assign hi_part_nxt = seconds[32:7];
  assign prod_nxt    = 53'(hi_part_nxt) * 53'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      hi_part_r <= hi_part_nxt;
      prod_r    <= prod_nxt;
      low_r     <= seconds[6:0];
      below0_r  <= seconds < LO_SEC;
      above0_r  <= seconds >= HI_SEC;
    end
  end

  logic [16:0] days_nxt;
  logic [26:0] rem_full;
  logic [16:0] sod_nxt;
  logic [16:0] days_r, sod_r;
  logic        below1_r, above1_r;

  assign days_nxt = prod_r[52:36];
  assign rem_full = 27'(hi_part_r) - 27'(days_nxt) * 27'(675);
  assign sod_nxt  = {rem_full[9:0], low_r};

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      days_r   <= days_nxt;
      sod_r    <= sod_nxt;
      below1_r <= below0_r;
      above1_r <= above0_r;
    end
  end

  assign days  = days_r;
  assign sod   = sod_r;
  assign below = below1_r;
  assign above = above1_r;

endmodule

/* sv/uft_date.sv */
// day count to gregorian year offset, month and day, seven stages
module uft_date (
  input  logic              clk,
  input  uft_pkg::pipe_ctl_t ctl,
  input  logic [16:0]       days,
  input  logic              below_in,
  input  logic              above_in,
  output logic [6:0]        year_off,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic              below,
  output logic              above
);
  import uft_pkg::*;

  // shift to a march-based calendar and find the 400-year era
  logic [19:0] z_nxt;
  logic [40:0] pera_nxt;
  logic [19:0] z_r;
  logic [40:0] pera_r;
  logic [1:0]  f2_r;

  assign z_nxt    = 20'(days) + EPOCH_SHIFT;
  assign pera_nxt = 41'(z_nxt) * 41'(ERA_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      z_r    <= z_nxt;
      pera_r <= pera_nxt;
      f2_r   <= {above_in, below_in};
    end
  end

  logic [2:0]  era_nxt;
  logic [19:0] doe_full;
  logic [2:0]  era3_r;
  logic [17:0] doe3_r;
  logic [1:0]  f3_r;

  assign era_nxt  = pera_r[40:38];
  assign doe_full = z_r - 20'(era_nxt) * ERA_DAYS;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      era3_r <= era_nxt;
      doe3_r <= doe_full[17:0];
      f3_r   <= f2_r;
    end
  end

  // century count minus the last-day correction, as compares
  logic [36:0] p1460_nxt;
  logic [1:0]  cent_nxt;
  logic [2:0]  era4_r;
  logic [17:0] doe4_r;
  logic [36:0] p1460_r;
  logic [1:0]  cent4_r;
  logic [1:0]  f4_r;

  assign p1460_nxt = 37'(doe3_r) * 37'(RECIP_1460);
  assign cent_nxt  = 2'(doe3_r >= 18'd36524) + 2'(doe3_r >= 18'd73048)
                   + 2'(doe3_r >= 18'd109572);

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      era4_r  <= era3_r;
      doe4_r  <= doe3_r;
      p1460_r <= p1460_nxt;
      cent4_r <= cent_nxt;
      f4_r    <= f3_r;
    end
  end

  logic [17:0] n_nxt;
  logic [36:0] p365_nxt;
  logic [2:0]  era5_r;
  logic [17:0] doe5_r;
  logic [36:0] p365_r;
  logic [1:0]  f5_r;

  assign n_nxt    = doe4_r - 18'(p1460_r[36:29]) + 18'(cent4_r);
  assign p365_nxt = 37'(n_nxt) * 37'(RECIP_365);

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      era5_r <= era4_r;
      doe5_r <= doe4_r;
      p365_r <= p365_nxt;
      f5_r   <= f4_r;
    end
  end

  logic [8:0]  yoe_nxt;
  logic [1:0]  c100_nxt;
  logic [17:0] doy_full;
  logic [2:0]  era6_r;
  logic [8:0]  yoe6_r;
  logic [8:0]  doy6_r;
  logic [1:0]  f6_r;

  assign yoe_nxt  = p365_r[35:27];
  assign c100_nxt = 2'(yoe_nxt >= 9'd100) + 2'(yoe_nxt >= 9'd200) + 2'(yoe_nxt >= 9'd300);
  assign doy_full = doe5_r - 18'(yoe_nxt) * 18'(365) - 18'(yoe_nxt[8:2]) + 18'(c100_nxt);

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      era6_r <= era5_r;
      yoe6_r <= yoe_nxt;
      doy6_r <= doy_full[8:0];
      f6_r   <= f5_r;
    end
  end

  logic [10:0] mpv_nxt;
  logic [22:0] pmp_nxt;
  logic [2:0]  era7_r;
  logic [8:0]  yoe7_r;
  logic [8:0]  doy7_r;
  logic [22:0] pmp_r;
  logic [1:0]  f7_r;

  assign mpv_nxt = 11'(doy6_r) * 11'(5) + 11'(2);
  assign pmp_nxt = 23'(mpv_nxt) * 23'(MP_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      era7_r <= era6_r;
      yoe7_r <= yoe6_r;
      doy7_r <= doy6_r;
      pmp_r  <= pmp_nxt;
      f7_r   <= f6_r;
    end
  end

  // back to a january-based month; jan and feb belong to the next year
  logic [3:0]  mp;
  logic [8:0]  day_full;
  logic [3:0]  month_nxt;
  logic [11:0] year_nxt;
  logic [11:0] yoff_full;
  logic [6:0]  yoff8_r;
  logic [3:0]  month8_r;
  logic [4:0]  day8_r;
  logic [1:0]  f8_r;

  assign mp        = pmp_r[22:19];
  assign day_full  = doy7_r - month_start(mp) + 9'd1;
  assign month_nxt = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
  assign year_nxt  = 12'(yoe7_r) + 12'(era7_r) * 12'(400) + 12'(month_nxt <= 4'd2);
  assign yoff_full = year_nxt - FAT_YEAR_BASE;

  always_ff @(posedge clk) begin
    if (ctl.en[8]) begin
      yoff8_r  <= yoff_full[6:0];
      month8_r <= month_nxt;
      day8_r   <= day_full[4:0];
      f8_r     <= f7_r;
    end
  end

  assign year_off = yoff8_r;
  assign month    = month8_r;
  assign day      = day8_r;
  assign below    = f8_r[0];
  assign above    = f8_r[1];

endmodule

/* sv/uft_clock.sv */
// second of day to packed fat time word, aligned with the date path
module uft_clock (
  input  logic              clk,
  input  uft_pkg::pipe_ctl_t ctl,
  input  logic [16:0]       sod,
  output logic [15:0]       time_word
);
  import uft_pkg::*;

  logic [34:0] pm_nxt;
  logic [16:0] sod2_r;
  logic [34:0] pm_r;

  assign pm_nxt = 35'(sod) * 35'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      sod2_r <= sod;
      pm_r   <= pm_nxt;
    end
  end

  logic [10:0] mt_nxt;
  logic [16:0] sec_full;
  logic [22:0] ph_nxt;
  logic [10:0] mt3_r;
  logic [5:0]  sec3_r;
  logic [22:0] ph3_r;

  assign mt_nxt   = pm_r[33:23];
  assign sec_full = sod2_r - 17'(mt_nxt) * 17'(60);
  assign ph_nxt   = 23'(mt_nxt) * 23'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      mt3_r  <= mt_nxt;
      sec3_r <= sec_full[5:0];
      ph3_r  <= ph_nxt;
    end
  end

  logic [4:0]  hour_nxt;
  logic [10:0] min_full;
  logic [15:0] tword4_r;

  assign hour_nxt = ph3_r[21:17];
  assign min_full = mt3_r - 11'(hour_nxt) * 11'(60);

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      tword4_r <= {hour_nxt, min_full[5:0], sec3_r[5:1]};
    end
  end

  // delay line to match the date path
  logic [15:0] dly_r [4];

  always_ff @(posedge clk) begin
    if (ctl.en[5]) dly_r[0] <= tword4_r;
    if (ctl.en[6]) dly_r[1] <= dly_r[0];
    if (ctl.en[7]) dly_r[2] <= dly_r[1];
    if (ctl.en[8]) dly_r[3] <= dly_r[2];
  end

  assign time_word = dly_r[3];

endmodule

/* sv/unix_time_to_fat_timestamp_core.sv */
// top level: pipeline control, saturation and output register
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, in_unix_seconds[32:0]     | sink
//  out     | out_valid, out_stall, out_fat_date[15:0],     | source
//          | out_fat_time[15:0], out_out_of_range          |
//
// ten register stages lie between an accepted beat and out_valid
// one beat per cycle sustained while out_stall stays low; the longest stage is one constant-reciprocal multiply
// each full stage holds while the one after it is full and not moving, so bubbles are squeezed out
// in_stall rises only when every stage up to the input holds a beat
// rst_n (synchronous) clears the stage valid bits only
module unix_time_to_fat_timestamp_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [32:0] in_unix_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_fat_date,
  output logic [15:0] out_fat_time,
  output logic        out_out_of_range
);
  import uft_pkg::*;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] en;
  pipe_ctl_t             ctl;

  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.en   = en;
  assign in_stall = !en[0];

  logic [16:0] days, sod;
  logic        split_below, split_above;
  logic [6:0]  year_off;
  logic [3:0]  month;
  logic [4:0]  day;
  logic        below, above;
  logic [15:0] time_word;

  uft_split u_split (
    .clk     (clk),
    .ctl     (ctl),
    .seconds (in_unix_seconds),
    .days    (days),
    .sod     (sod),
    .below   (split_below),
    .above   (split_above)
  );

  uft_date u_date (
    .clk      (clk),
    .ctl      (ctl),
    .days     (days),
    .below_in (split_below),
    .above_in (split_above),
    .year_off (year_off),
    .month    (month),
    .day      (day),
    .below    (below),
    .above    (above)
  );

  uft_clock u_clock (
    .clk       (clk),
    .ctl       (ctl),
    .sod       (sod),
    .time_word (time_word)
  );

  logic [15:0] date_nxt, time_nxt;
  logic [15:0] date_r, time_r;
  logic        oor_r;

  always_comb begin
    if (below) begin
      date_nxt = FAT_DATE_MIN;
      time_nxt = FAT_TIME_MIN;
    end else if (above) begin
      date_nxt = FAT_DATE_MAX;
      time_nxt = FAT_TIME_MAX;
    end else begin
      date_nxt = {year_off, month, day};
      time_nxt = time_word;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      date_r <= date_nxt;
      time_r <= time_nxt;
      oor_r  <= below || above;
    end
  end

  assign out_valid        = v_r[NUM_STAGES-1];
  assign out_fat_date     = date_r;
  assign out_fat_time     = time_r;
  assign out_out_of_range = oor_r;

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted beat did not enter the first stage");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && out_stall |-> in_stall)
    else $error("input taken while the pipeline is full and blocked");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      (out_fat_date == FAT_DATE_MIN && out_fat_time == FAT_TIME_MIN) ||
      (out_fat_date == FAT_DATE_MAX && out_fat_time == FAT_TIME_MAX))
    else $error("saturated beat carries a wrong timestamp");

  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_fat_date[8:5] >= 4'd1 && out_fat_date[8:5] <= 4'd12 &&
      out_fat_date[4:0] != 5'd0 && out_fat_time[4:0] <= 5'd29 &&
      out_fat_time[10:5] <= 6'd59 && out_fat_time[15:11] <= 5'd23)
    else $error("encoded timestamp field out of its legal range");

endmodule

/* tb/sv/unix_time_to_fat_timestamp_core_tb.sv */
// testbench for the unix time to fat timestamp encoder: directed and random beats, scoreboard
`timescale 1ns / 1ps

module unix_time_to_fat_timestamp_core_tb;

  localparam logic [32:0] FIRST_FAT_SEC = 33'd315532800;   // 1980-01-01 00:00:00
  localparam logic [32:0] PAST_FAT_SEC  = 33'd4354819200;  // 2108-01-01 00:00:00
  localparam logic [32:0] MAX_SEC       = 33'h1_FFFF_FFFF;
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned FIRST_FAT_DAY = 3652;
  localparam int unsigned LAST_FAT_DAY  = 50402;
  localparam int unsigned YEAR_FIRST    = 1980;
  localparam int unsigned YEAR_LAST     = 2107;
  localparam logic [15:0] DATE_FLOOR    = 16'h0021;
  localparam logic [15:0] TOD_FLOOR     = 16'h0000;
  localparam logic [15:0] DATE_CEIL     = 16'hFF9F;
  localparam logic [15:0] TOD_CEIL      = 16'hBF7D;
  localparam int          RANDOM_BEATS  = 450;

  typedef struct {
    logic [15:0] date;
    logic [15:0] tod;
    logic        clamped;
  } fat_stamp_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_STREAK} stall_mode_t;

  // civil-date split of unix seconds, packed into fat date and time words or clamped to the floor or ceiling
  function automatic fat_stamp_t encode_fat_stamp(input logic [32:0] secs);
    longint unsigned t, days, sod, z, era, doe, yoe, doy, mp, d, m, y;
    fat_stamp_t r;
    t    = longint'(secs);
    days = t / SEC_PER_DAY;
    sod  = t % SEC_PER_DAY;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    d    = doy - (153 * mp + 2) / 5 + 1;
    m    = (mp < 10) ? mp + 3 : mp - 9;
    y    = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    if (y < YEAR_FIRST) begin
      r = '{DATE_FLOOR, TOD_FLOOR, 1'b1};
    end else if (y > YEAR_LAST) begin
      r = '{DATE_CEIL, TOD_CEIL, 1'b1};
    end else begin
      r.date    = {7'(y - YEAR_FIRST), 4'(m), 5'(d)};
      r.tod     = {5'(sod / 3600), 6'((sod / 60) % 60), 5'((sod % 60) / 2)};
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  class fat_stamp_scoreboard;
    fat_stamp_t pending_stamps[$];
    int mismatches;
    int n_encoded;
    int n_low;
    int n_high;

    function void note_stamp(input logic [32:0] secs);
      pending_stamps.push_back(encode_fat_stamp(secs));
    endfunction

    function void check_stamp(input logic [15:0] date, input logic [15:0] tod,
                              input logic clamped);
      fat_stamp_t want;
      if (pending_stamps.size() == 0) begin
        $error("result beat with no pending timestamp: date %h time %h", date, tod);
        mismatches++;
        return;
      end
      want = pending_stamps.pop_front();
      if (date !== want.date) begin
        $error("fat_date: expected %h, actual %h", want.date, date);
        mismatches++;
      end
      if (tod !== want.tod) begin
        $error("fat_time: expected %h, actual %h", want.tod, tod);
        mismatches++;
      end
      if (clamped !== want.clamped) begin
        $error("out_of_range: expected %b, actual %b", want.clamped, clamped);
        mismatches++;
      end
      if (!want.clamped) n_encoded++;
      else if (want.date == DATE_FLOOR) n_low++;
      else n_high++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [32:0] in_unix_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_fat_date;
  logic [15:0] out_fat_time;
  logic        out_out_of_range;

  fat_stamp_scoreboard board;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [5:0]  stall_tick = '0;

  unix_time_to_fat_timestamp_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_unix_seconds  (in_unix_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fat_date     (out_fat_date),
    .out_fat_time     (out_fat_time),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted beats, stall on a mode that changes whenever stall_tick wraps
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_stamp(out_fat_date, out_fat_time, out_out_of_range);
    end
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 6);
      STALL_STREAK: out_stall <= (stall_tick[3:0] < 4'd12);
      default:      out_stall <= 1'b0;
    endcase
  end

  // one beat, bursts of random length separated by random gaps that may be empty
  task automatic send_stamp(input logic [32:0] secs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_unix_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_stamp(secs);
  endtask

  function automatic logic [32:0] pick_seconds();
    logic [32:0] day;
    case ($urandom_range(0, 9))
      0, 1: return {1'($urandom_range(0, 1)), 32'($urandom)};
      2:    return FIRST_FAT_SEC - 33'd300 + 33'($urandom_range(0, 600));
      3:    return PAST_FAT_SEC - 33'd300 + 33'($urandom_range(0, 600));
      4: begin
        // last or first seconds of a random day inside the fat range
        day = 33'($urandom_range(FIRST_FAT_DAY, LAST_FAT_DAY));
        if ($urandom_range(0, 1) == 1) return (day + 33'd1) * SEC_PER_DAY - 33'($urandom_range(1, 3));
        return day * SEC_PER_DAY + 33'($urandom_range(0, 2));
      end
      default: return FIRST_FAT_SEC + 33'($urandom_range(0, 32'd4039286399));
    endcase
  endfunction

  initial begin
    logic [32:0] directed[$];
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{33'd0, 33'd1, FIRST_FAT_SEC - 33'd1, FIRST_FAT_SEC, FIRST_FAT_SEC + 33'd1,
                 PAST_FAT_SEC - 33'd2, PAST_FAT_SEC - 33'd1, PAST_FAT_SEC, PAST_FAT_SEC + 33'd1,
                 33'h0_FFFF_FFFF, 33'h1_0000_0000, MAX_SEC, 33'h0_AAAA_AAAA, 33'h1_5555_5555,
                 33'd951782400, 33'd951868799,      // a leap day in a 400-year leap year
                 33'd4107542399, 33'd4107542400,    // 2100 is not a leap year
                 33'd946684799, 33'd946684800,      // year roll
                 33'd1709251199, 33'd1704067201};   // odd seconds truncate
    foreach (directed[i]) send_stamp(directed[i]);

    repeat (RANDOM_BEATS) send_stamp(pick_seconds());
    in_valid <= 1'b0;

    while (board.pending_stamps.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("checked %0d timestamps: %0d encoded, %0d clamped to 1980, %0d clamped to 2107",
             board.n_encoded + board.n_low + board.n_high, board.n_encoded, board.n_low,
             board.n_high);
    $display("%0d field mismatches or unexpected beats", board.mismatches);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", board.pending_stamps.size());
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
sv/uft_pkg.sv
sv/uft_split.sv
sv/uft_date.sv
sv/uft_clock.sv
sv/unix_time_to_fat_timestamp_core.sv
tb/sv/unix_time_to_fat_timestamp_core_tb.sv
